// ===== hdl/ffba_pkg.sv =====
// ffba_pkg: shared constants, codes and types of the first-fit block allocator.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package ffba_pkg;

    localparam int ADDR_W = 24;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 5;

    localparam int DEF_MAX_BLOCKS      = 64;
    localparam int DEF_HEADER_BYTES    = 24;
    localparam int DEF_CHUNK_BYTES     = 1024 * 1024;
    localparam int DEF_MAX_CHUNKS      = 16;
    localparam int DEF_MIN_SPLIT_BYTES = 8;

    localparam logic [CFG_W-1:0] CHUNK_LIMIT_RST = CFG_W'(16);

    localparam logic [FUNC_W-1:0] F_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] F_FREE    = 2'd1;
    localparam logic [FUNC_W-1:0] F_REALLOC = 2'd2;
    localparam logic [FUNC_W-1:0] F_NONE    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOMEM  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD    = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              free;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_NEXT,
        S_DECIDE,
        S_GROW,
        S_MOVE,
        S_FIX0,
        S_FIX1,
        S_OUT
    } t_state;

    typedef enum logic {
        M_FIT,
        M_FIND
    } t_mode;

endpackage

`default_nettype wire

// ===== hdl/ffba_if.sv =====
// ffba_if: valid/ready channel interfaces for requests, results and configuration.
// Depends on ffba_pkg for field widths.
`default_nettype none

interface ffba_req_if import ffba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] address;

    modport source (output valid, func, request_size, address, input ready);
    modport sink   (input valid, func, request_size, address, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_address;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] copy_from;
    logic [ADDR_W-1:0] copy_length;

    modport source (output valid, result_address, status, copy_from, copy_length,
                    input ready);
    modport sink   (input valid, result_address, status, copy_from, copy_length,
                    output ready);
endinterface

interface ffba_cfg_if import ffba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] chunk_limit;

    modport source (output valid, chunk_limit, input ready);
    modport sink   (input valid, chunk_limit, output ready);
endinterface

`default_nettype wire

// ===== hdl/first_fit_block_allocator_top.sv =====
// First-fit heap block allocator. The block table lives in one memory (one write, one
// registered read per cycle) and every request is handled one at a time by a sequencer.
// A table walk reads one entry per cycle through the read port; inserting or removing an
// entry shifts the tail of the table, one entry per cycle. Growing the heap adds one chunk
// per cycle while the chunks in use stay within the chunk limit (capped at MAX_CHUNKS).
// A realloc that moves runs an alloc and a free back to back and so takes up to about
// three table walks plus two shifts.
// The next request is taken as soon as the result sits in the output register.
// Depends on ffba_pkg and the channel interfaces in ffba_if.sv.
`default_nettype none

module first_fit_block_allocator_top import ffba_pkg::*; #(
    parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES    = DEF_HEADER_BYTES,
    parameter int CHUNK_BYTES     = DEF_CHUNK_BYTES,
    parameter int MAX_CHUNKS      = DEF_MAX_CHUNKS,
    parameter int MIN_SPLIT_BYTES = DEF_MIN_SPLIT_BYTES
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ffba_req_if.sink     i_req,
    ffba_rsp_if.source   o_rsp,
    ffba_cfg_if.sink     i_cfg
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam longint unsigned HEAP_MAX = longint'(MAX_CHUNKS) * longint'(CHUNK_BYTES);
    localparam int HE_W  = $clog2(HEAP_MAX + 1);
    localparam int GW    = (HE_W > ADDR_W + 2) ? HE_W : ADDR_W + 2;
    localparam int CH_W  = $clog2(MAX_CHUNKS + 1);
    localparam int LW    = ((CH_W > CFG_W) ? CH_W : CFG_W) + 1;
    localparam int SW    = ADDR_W + 2;

    localparam logic [ADDR_W-1:0] HDR    = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W:0]   HDR_X  = (ADDR_W+1)'(HEADER_BYTES);
    localparam logic [SW-1:0]     MINS_X = SW'(HEADER_BYTES + MIN_SPLIT_BYTES);
    localparam logic [GW-1:0]     HDR_G  = GW'(HEADER_BYTES);
    localparam logic [GW-1:0]     CHUNK  = GW'(CHUNK_BYTES);
    localparam logic [LW-1:0]     MAXC   = LW'(MAX_CHUNKS);
    localparam logic [CNT_W-1:0]  MAXB   = CNT_W'(MAX_BLOCKS);

    // block table
    t_entry mem [MAX_BLOCKS];
    t_entry r_rd_data;
    logic   mem_we;
    logic [IDX_W-1:0] mem_wa, mem_ra;
    t_entry mem_wd;

    t_state r_state, n_state;
    t_mode  r_mode;

    logic [FUNC_W-1:0] r_func;
    logic [ADDR_W-1:0] r_req, r_addr;
    logic              r_post;

    logic [CNT_W-1:0]  r_count;
    logic [GW-1:0]     r_heap_end;
    logic [LW-1:0]     r_used;
    logic [CFG_W-1:0]  r_chunk_limit;

    logic [CNT_W-1:0]  r_scan_idx;
    logic              r_chk_v;
    logic [IDX_W-1:0]  r_chk_idx;
    logic [IDX_W-1:0]  r_k;
    t_entry            r_prev, r_cur, r_next;
    logic              r_has_next;

    logic [GW-1:0]     r_gsz;
    logic [LW-1:0]     r_gch;

    logic [IDX_W-1:0]  r_mv_rd, r_wdst;
    logic [CNT_W-1:0]  r_mv_n;
    logic              r_mv_up, r_mv_two, r_wpend;

    logic              r_fx0_v, r_fx1_v;
    logic [IDX_W-1:0]  r_fx0_idx, r_fx1_idx;
    t_entry            r_fx0_e, r_fx1_e;

    logic [ADDR_W-1:0] r_res, r_cfrom, r_clen;
    logic [STAT_W-1:0] r_status;

    logic              r_o_v;
    logic [ADDR_W-1:0] r_o_res, r_o_cfrom, r_o_clen;
    logic [STAT_W-1:0] r_o_status;

    // ---------------------------------------------------------------- decode
    logic req_fire, load_out;
    logic chk_fit, chk_find, scan_hit, scan_end;
    logic d_split, d_free, d_pf, d_nf, d_size_ok;
    logic [LW-1:0] lim, used_next;
    logic [GW-1:0] need;
    logic g_done, g_fail;
    logic post_free;
    logic [CNT_W-1:0] kx;

    assign req_fire = i_req.valid && i_req.ready;
    assign load_out = (r_state == S_OUT) && (!r_o_v || o_rsp.ready);
    assign kx       = CNT_W'(r_k);

    assign chk_fit  = r_rd_data.free && (r_rd_data.size >= r_req);
    assign chk_find = ({1'b0, r_rd_data.start} + HDR_X) == {1'b0, r_addr};
    assign scan_hit = r_chk_v && ((r_mode == M_FIT) ? chk_fit : chk_find);
    assign scan_end = !r_chk_v && (r_scan_idx >= r_count);

    assign d_split   = ({2'b00, r_cur.size} >= ({2'b00, r_req} + MINS_X)) && (r_count < MAXB);
    assign d_free    = (r_func == F_FREE) || r_post || (r_req == '0);
    assign d_pf      = (r_k != '0) && r_prev.free;
    assign d_nf      = r_has_next && r_next.free;
    assign d_size_ok = r_cur.size >= r_req;

    assign lim       = (LW'(r_chunk_limit) < MAXC) ? LW'(r_chunk_limit) : MAXC;
    assign used_next = r_used + r_gch;
    assign need      = GW'(r_req) + HDR_G;
    assign g_done    = r_gsz >= need;
    assign g_fail    = (r_count >= MAXB) || (!g_done && (used_next >= lim));

    // a realloc that moved still has to release its old block
    assign post_free = (r_mode == M_FIT) && (r_func == F_REALLOC) && (r_addr != '0) && !r_post;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    if (i_req.func == F_ALLOC || (i_req.func == F_REALLOC &&
                                                  i_req.address == '0)) begin
                        n_state = (i_req.request_size == '0) ? S_OUT : S_SCAN;
                    end else if (i_req.func == F_FREE || i_req.func == F_REALLOC) begin
                        n_state = (i_req.address == '0) ? S_OUT : S_SCAN;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = (r_mode == M_FIT) ? S_DECIDE : S_NEXT;
                end else if (scan_end) begin
                    n_state = (r_mode == M_FIT) ? S_GROW : S_OUT;
                end
            end
            S_NEXT:   n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_mode == M_FIT) begin
                    n_state = S_MOVE;
                end else if (r_cur.free) begin
                    n_state = S_OUT;
                end else if (d_free) begin
                    n_state = S_MOVE;
                end else if (d_size_ok) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_GROW: begin
                if (g_fail) begin
                    n_state = S_OUT;
                end else if (g_done) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (r_mv_n == '0 && !r_wpend) begin
                    n_state = S_FIX0;
                end
            end
            S_FIX0: n_state = S_FIX1;
            S_FIX1: n_state = post_free ? S_SCAN : S_OUT;
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wdst;
        mem_wd = r_rd_data;
        mem_ra = r_mv_rd;
        case (r_state)
            S_SCAN: mem_ra = r_scan_idx[IDX_W-1:0];
            S_MOVE: begin
                mem_we = r_wpend;
            end
            S_FIX0: begin
                mem_we = r_fx0_v;
                mem_wa = r_fx0_idx;
                mem_wd = r_fx0_e;
            end
            S_FIX1: begin
                mem_we = r_fx1_v;
                mem_wa = r_fx1_idx;
                mem_wd = r_fx1_e;
            end
            default: mem_we = 1'b0;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid          = r_o_v;
    assign o_rsp.result_address = r_o_res;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.copy_from      = r_o_cfrom;
    assign o_rsp.copy_length    = r_o_clen;

    // ---------------------------------------------------------------- memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_heap_end    <= '0;
            r_used        <= '0;
            r_chunk_limit <= CHUNK_LIMIT_RST;
            r_o_v         <= 1'b0;
            r_chk_v       <= 1'b0;
            r_wpend       <= 1'b0;
            r_mv_n        <= '0;
            r_post        <= 1'b0;
            r_mode        <= M_FIT;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                r_chunk_limit <= i_cfg.chunk_limit;
            end

            if (load_out) begin
                r_o_v      <= 1'b1;
                r_o_res    <= r_res;
                r_o_status <= r_status;
                r_o_cfrom  <= r_cfrom;
                r_o_clen   <= r_clen;
            end else if (o_rsp.ready) begin
                r_o_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_func     <= i_req.func;
                    r_req      <= i_req.request_size;
                    r_addr     <= i_req.address;
                    r_res      <= '0;
                    r_cfrom    <= '0;
                    r_clen     <= '0;
                    r_post     <= 1'b0;
                    r_scan_idx <= '0;
                    r_chk_v    <= 1'b0;
                    r_status   <= ((i_req.func == F_ALLOC || (i_req.func == F_REALLOC &&
                                    i_req.address == '0)) && i_req.request_size == '0) ?
                                  ST_ZERO : ST_OK;
                    if (i_req.func == F_ALLOC || (i_req.func == F_REALLOC &&
                                                  i_req.address == '0)) begin
                        r_mode <= M_FIT;
                    end else begin
                        r_mode <= M_FIND;
                    end
                end
                S_SCAN: begin
                    if (r_scan_idx < r_count) begin
                        r_chk_v    <= 1'b1;
                        r_chk_idx  <= r_scan_idx[IDX_W-1:0];
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end else begin
                        r_chk_v <= 1'b0;
                    end
                    if (scan_hit) begin
                        r_cur <= r_rd_data;
                        r_k   <= r_chk_idx;
                    end else if (r_chk_v) begin
                        r_prev <= r_rd_data;
                    end
                    if (scan_end) begin
                        r_gsz <= '0;
                        r_gch <= '0;
                        if (r_mode == M_FIND) begin
                            r_status <= ST_BAD;
                        end
                    end
                end
                S_NEXT: begin
                    // the read of the following entry was issued alongside the hit
                    r_next     <= r_rd_data;
                    r_has_next <= (kx + 1'b1) < r_count;
                end
                S_DECIDE: begin
                    r_wpend <= 1'b0;
                    r_fx0_v <= (r_mode == M_FIT) || (!r_cur.free && d_free);
                    r_fx1_v <= (r_mode == M_FIT) && d_split;
                    if (r_mode == M_FIT) begin
                        r_res     <= r_cur.start + HDR;
                        r_fx0_idx <= r_k;
                        r_fx0_e   <= '{start: r_cur.start,
                                       size:  d_split ? r_req : r_cur.size,
                                       free:  1'b0};
                        if (d_split) begin
                            r_fx1_idx <= r_k + 1'b1;
                            r_fx1_e   <= '{start: r_cur.start + HDR + r_req,
                                           size:  r_cur.size - r_req - HDR,
                                           free:  1'b1};
                            r_count   <= r_count + 1'b1;
                            r_mv_up   <= 1'b1;
                            r_mv_rd   <= IDX_W'(r_count - 1'b1);
                            r_mv_n    <= r_count - 1'b1 - kx;
                        end else begin
                            r_mv_n    <= '0;
                        end
                    end else if (r_cur.free) begin
                        r_status <= ST_BAD;
                    end else if (d_free) begin
                        if (r_func == F_REALLOC && !r_post) begin
                            r_status <= ST_ZERO;
                        end
                        r_mv_up <= 1'b0;
                        if (d_pf && d_nf) begin
                            r_fx0_idx <= r_k - 1'b1;
                            r_fx0_e   <= '{start: r_prev.start,
                                           size:  r_prev.size + HDR + HDR + r_cur.size
                                                  + r_next.size,
                                           free:  1'b1};
                            r_mv_two  <= 1'b1;
                            r_mv_rd   <= r_k + IDX_W'(2);
                            r_mv_n    <= r_count - kx - CNT_W'(2);
                            r_count   <= r_count - CNT_W'(2);
                        end else if (d_pf) begin
                            r_fx0_idx <= r_k - 1'b1;
                            r_fx0_e   <= '{start: r_prev.start,
                                           size:  r_prev.size + HDR + r_cur.size,
                                           free:  1'b1};
                            r_mv_two  <= 1'b0;
                            r_mv_rd   <= r_k + 1'b1;
                            r_mv_n    <= r_count - kx - 1'b1;
                            r_count   <= r_count - 1'b1;
                        end else if (d_nf) begin
                            r_fx0_idx <= r_k;
                            r_fx0_e   <= '{start: r_cur.start,
                                           size:  r_cur.size + HDR + r_next.size,
                                           free:  1'b1};
                            r_mv_two  <= 1'b0;
                            r_mv_rd   <= r_k + IDX_W'(2);
                            r_mv_n    <= r_count - kx - CNT_W'(2);
                            r_count   <= r_count - 1'b1;
                        end else begin
                            r_fx0_idx <= r_k;
                            r_fx0_e   <= '{start: r_cur.start, size: r_cur.size,
                                           free: 1'b1};
                            r_mv_n    <= '0;
                        end
                    end else if (d_size_ok) begin
                        r_res <= r_addr;
                    end else begin
                        // move: allocate first, the old block is freed afterwards
                        r_cfrom    <= r_addr;
                        r_clen     <= r_cur.size;
                        r_mode     <= M_FIT;
                        r_scan_idx <= '0;
                        r_chk_v    <= 1'b0;
                    end
                end
                S_GROW: begin
                    if (g_fail) begin
                        r_status <= ST_NOMEM;
                        r_res    <= '0;
                        r_cfrom  <= '0;
                        r_clen   <= '0;
                    end else if (g_done) begin
                        r_fx0_v    <= 1'b1;
                        r_fx1_v    <= 1'b0;
                        r_fx0_idx  <= r_count[IDX_W-1:0];
                        r_fx0_e    <= '{start: r_heap_end[ADDR_W-1:0],
                                        size:  ADDR_W'(r_gsz - HDR_G),
                                        free:  1'b0};
                        r_mv_n     <= '0;
                        r_wpend    <= 1'b0;
                        r_count    <= r_count + 1'b1;
                        r_res      <= ADDR_W'(r_heap_end + HDR_G);
                        r_heap_end <= r_heap_end + r_gsz;
                        r_used     <= used_next;
                    end else begin
                        r_gsz <= r_gsz + CHUNK;
                        r_gch <= r_gch + 1'b1;
                    end
                end
                S_MOVE: begin
                    if (r_mv_n != '0) begin
                        r_wpend <= 1'b1;
                        r_wdst  <= r_mv_up ? (r_mv_rd + 1'b1) :
                                   (r_mv_two ? (r_mv_rd - IDX_W'(2)) : (r_mv_rd - 1'b1));
                        r_mv_rd <= r_mv_up ? (r_mv_rd - 1'b1) : (r_mv_rd + 1'b1);
                        r_mv_n  <= r_mv_n - 1'b1;
                    end else begin
                        r_wpend <= 1'b0;
                    end
                end
                S_FIX1: begin
                    if (post_free) begin
                        r_post     <= 1'b1;
                        r_mode     <= M_FIND;
                        r_scan_idx <= '0;
                        r_chk_v    <= 1'b0;
                    end
                end
                default: begin
                    r_chk_v <= r_chk_v;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= MAXB)
        else $error("block table overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_used <= MAXC)
        else $error("heap grew past the chunk maximum");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     (r_state == S_IDLE || r_state == S_OUT) |-> !mem_we)
        else $error("table written outside a request");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     req_fire |=> (r_state != S_IDLE))
        else $error("accepted request produced no work");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     (r_state == S_MOVE && r_mv_n == '0 && !r_wpend) |=> r_state == S_FIX0)
        else $error("shift did not hand over to fix-up");

endmodule

`default_nettype wire
